[rtl/core/sac_pkg.sv]
// Shared types and constants of the stick axis conditioner.
package sac_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    RegRangeLow    = 3'd0,
    RegRangeCenter = 3'd1,
    RegRangeHigh   = 3'd2,
    RegUnipolar    = 3'd3,
    RegInvert      = 3'd4,
    RegShift       = 3'd5,
    RegExpo        = 3'd6,
    RegDeadzone    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] range_low;
    logic [15:0] range_center;
    logic [15:0] range_high;
    logic        unipolar_mode;
    logic        invert_output;
    logic [2:0]  smoothing_shift;
    logic [6:0]  expo_percent;
    logic [15:0] center_deadzone;
  } cfg_t;

  // Datapath operations selected by the controller.
  typedef enum logic [2:0] {
    OpNone,
    OpFilter,
    OpMap,
    OpDzone,
    OpCube1,
    OpCube2,
    OpExpo,
    OpFinish
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   div_start;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_sts_t;

  // Divider operand widths: dividends up to 48 bits, divisors up to 17 bits.
  localparam int unsigned DivNW = 48;
  localparam int unsigned DivDW = 17;
  localparam int unsigned DivCntW = 6;

endpackage

[rtl/core/sac_divider.sv]
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
module sac_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sac_pkg::DivNW-1:0]  num_i,
  input  logic [sac_pkg::DivDW-1:0]  den_i,
  output logic                       busy_o,
  output logic [sac_pkg::DivNW-1:0]  quot_o
);
  import sac_pkg::*;

  logic [DivNW-1:0] quot_q, quot_d;
  logic [DivDW:0]   rem_q, rem_d;
  logic [DivDW-1:0] den_q, den_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [DivDW:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[DivDW-1:0], quot_q[DivNW-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = DivCntW'(DivNW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[DivNW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[DivNW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

  property p_busy_counts;
    @(posedge clk_i) disable iff (!rst_ni) (busy_q && !start_i && cnt_q != '0) |=> busy_q;
  endproperty
  a_busy_counts: assert property (p_busy_counts) else $error("divider stopped early");

  property p_start_busy;
    @(posedge clk_i) disable iff (!rst_ni) start_i |=> (busy_q && cnt_q == DivCntW'(DivNW - 1));
  endproperty
  a_start_busy: assert property (p_start_busy) else $error("divider did not start");

  property p_done;
    @(posedge clk_i) disable iff (!rst_ni) (busy_q && !start_i && cnt_q == '0) |=> !busy_q;
  endproperty
  a_done: assert property (p_done) else $error("divider overran");

endmodule

[rtl/core/sac_datapath.sv]
// Datapath: filter, range mapping, deadzone, expo and output inversion with one shared divider.
module sac_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sac_pkg::cfg_t        cfg_i,
  input  logic                 cfg_wr_i,
  input  logic                 load_i,
  input  logic [15:0]          sample_i,
  input  sac_pkg::dp_cmd_t     cmd_i,
  output sac_pkg::dp_sts_t     sts_o,
  output logic [15:0]          result_o
);
  import sac_pkg::*;

  // Reciprocal of one hundred scaled by 2^29, exact for every blend sum below 2^22.
  localparam logic [22:0] Recip100 = 23'd5368710;

  logic [15:0] smooth_q, smooth_d;
  logic        primed_q, primed_d;
  logic [15:0] val_q, val_d;     // working value on the 0..65535 scale
  logic        neg_q, neg_d;     // sign of the centred value
  logic [15:0] mag_q, mag_d;     // magnitude of the centred value
  logic [31:0] sq_q, sq_d;       // magnitude squared
  logic [15:0] cube_q, cube_d;   // cube magnitude over 2^30
  logic [15:0] res_q, res_d;
  logic        passv_q, passv_d; // deadzone produced final value
  logic [22:0] expo_mag_q, expo_mag_d; // magnitude of the expo blend sum
  logic        expo_neg_q, expo_neg_d; // sign of the blended value

  logic [DivNW-1:0] div_num;
  logic [DivDW-1:0] div_den;
  logic             div_busy;
  logic [DivNW-1:0] div_quot;

  sac_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quot_o (div_quot)
  );

  // Clamp and map selection.
  logic [15:0] clamped;
  logic        inverted;
  logic        use_upper;
  logic [16:0] dz_rem;
  logic [15:0] dz_w;
  logic        dz_on;

  // Filter arithmetic.
  logic signed [17:0] delta, step, mag_s, lim;
  logic [15:0]        filt_out;

  always_comb begin
    inverted  = cfg_i.range_low > cfg_i.range_high;
    clamped   = val_q;
    if (val_q < cfg_i.range_low) clamped = cfg_i.range_low;
    if (val_q > cfg_i.range_high) clamped = cfg_i.range_high;
    if (!(val_q < cfg_i.range_low) && !(val_q > cfg_i.range_high)) clamped = val_q;
    use_upper = clamped > cfg_i.range_center;
    dz_w      = cfg_i.center_deadzone;
    dz_on     = (dz_w != '0) && (dz_w < 16'd32767);
    dz_rem    = 17'd32767 - {1'b0, dz_w};
  end

  always_comb begin
    delta = $signed({2'b00, val_q}) - $signed({2'b00, smooth_q});
    lim   = $signed(18'((18'd1 << cfg_i.smoothing_shift) - 18'd1));
    mag_s = -delta;
    if (delta >= 0) begin
      step = delta >>> cfg_i.smoothing_shift;
    end else begin
      step = -((mag_s + lim) >>> cfg_i.smoothing_shift);
    end
    if (step == 0 && delta != 0) begin
      step = (delta > 0) ? 18'sd1 : -18'sd1;
    end
    filt_out = 16'($signed({2'b00, smooth_q}) + step);
  end

  // Expo blend: (100-e)*m + e*c, where the cube shares the sign of the centred value.
  logic signed [8:0]  expo_w;
  logic signed [25:0] expo_a;
  logic [45:0]        expo_prod;

  always_comb begin
    expo_w    = 9'sd100 - $signed({2'b00, cfg_i.expo_percent});
    expo_a    = $signed({1'b0, mag_q}) * expo_w
                + $signed({1'b0, cube_q}) * $signed({2'b00, cfg_i.expo_percent});
    expo_prod = 46'(expo_mag_q) * 46'(Recip100);
  end

  // Divider operands by operation.
  logic [16:0] map_num_base;
  always_comb begin
    div_num = '0;
    div_den = '0;
    map_num_base = '0;
    unique case (cmd_i.op)
      OpMap: begin
        if (cfg_i.unipolar_mode) begin
          div_num = DivNW'(({1'b0, clamped} - {1'b0, cfg_i.range_low}) * 33'd65535);
          div_den = DivDW'({1'b0, cfg_i.range_high} - {1'b0, cfg_i.range_low});
        end else if (use_upper) begin
          div_num = DivNW'(({1'b0, clamped} - {1'b0, cfg_i.range_center}) * 33'd32767);
          div_den = DivDW'({1'b0, cfg_i.range_high} - {1'b0, cfg_i.range_center});
        end else begin
          map_num_base = {1'b0, clamped} - {1'b0, cfg_i.range_low};
          div_num = DivNW'({map_num_base, 15'd0});
          div_den = DivDW'({1'b0, cfg_i.range_center} - {1'b0, cfg_i.range_low});
        end
      end
      OpDzone: begin
        // The magnitude is formed from the mapped value in this same cycle.
        div_num = DivNW'(({1'b0, mag_d} - {1'b0, dz_w}) * 33'd32767);
        div_den = dz_rem;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  // Saturating result after adding a signed offset to centre.
  function automatic logic [15:0] sat_center(logic n, logic [31:0] m);
    logic signed [33:0] t;
    t = n ? (34'sd32768 - $signed({2'b00, m})) : (34'sd32768 + $signed({2'b00, m}));
    if (t < 0) sat_center = 16'd0;
    else if (t > 34'sd65535) sat_center = 16'hFFFF;
    else sat_center = t[15:0];
  endfunction

  logic [15:0] map_val;
  logic [16:0] ctr_x;
  logic [31:0] dz_scaled;

  always_comb begin
    smooth_d = smooth_q;
    primed_d = primed_q;
    val_d    = val_q;
    neg_d    = neg_q;
    mag_d    = mag_q;
    sq_d     = sq_q;
    cube_d   = cube_q;
    res_d    = res_q;
    passv_d  = passv_q;
    expo_mag_d = expo_mag_q;
    expo_neg_d = expo_neg_q;
    map_val  = '0;
    ctr_x    = '0;
    dz_scaled = '0;
    if (load_i) begin
      val_d = sample_i;
    end
    unique case (cmd_i.op)
      OpFilter: begin
        if (!primed_q || cfg_i.smoothing_shift == '0) begin
          smooth_d = val_q;
          val_d    = val_q;
        end else begin
          smooth_d = filt_out;
          val_d    = filt_out;
        end
        primed_d = 1'b1;
      end
      OpMap: begin
        // Result of the divide taken when the controller moves to deadzone.
      end
      OpDzone: begin
        // Map result in the divider: form the mapped value first.
        if (cfg_i.unipolar_mode) begin
          if (inverted || cfg_i.range_high == cfg_i.range_low) map_val = '0;
          else map_val = div_quot[15:0];
        end else if (inverted) begin
          map_val = 16'd32768;
        end else if (use_upper) begin
          if (cfg_i.range_high > cfg_i.range_center) map_val = 16'd32768 + div_quot[15:0];
          else map_val = 16'd32768;
        end else begin
          if (cfg_i.range_center > cfg_i.range_low) map_val = div_quot[15:0];
          else map_val = 16'd32768;
        end
        val_d = map_val;
        ctr_x = {1'b0, map_val} - 17'd32768;
        neg_d = ctr_x[16];
        mag_d = ctr_x[16] ? 16'(17'd0 - ctr_x) : ctr_x[15:0];
        passv_d = 1'b0;
        if (!cfg_i.unipolar_mode && dz_on) begin
          if ((ctr_x[16] ? 17'(17'd0 - ctr_x) : ctr_x) <= {1'b0, dz_w}) begin
            val_d = 16'd32768;
            mag_d = '0;
            neg_d = 1'b0;
            passv_d = 1'b1;
          end
        end
      end
      OpCube1: begin
        // Deadzone divide done (if used); recentre.
        if (!cfg_i.unipolar_mode && dz_on && !passv_q) begin
          dz_scaled = (div_quot[31:0] > 32'd32767) ? 32'd32767 : div_quot[31:0];
          val_d = sat_center(neg_q, dz_scaled);
          mag_d = dz_scaled[15:0];
        end
        sq_d = 32'(mag_d) * 32'(mag_d);
      end
      OpCube2: begin
        cube_d = 16'((48'(sq_q) * 48'(mag_q)) >> 30);
      end
      OpExpo: begin
        expo_neg_d = neg_q ^ expo_a[25];
        expo_mag_d = expo_a[25] ? 23'(-expo_a) : expo_a[22:0];
      end
      OpFinish: begin
        res_d = val_q;
        if (!cfg_i.unipolar_mode && cfg_i.expo_percent != '0) begin
          res_d = sat_center(expo_neg_q, {15'd0, expo_prod[45:29]});
        end
        if (cfg_i.invert_output) res_d = 16'hFFFF - res_d;
      end
      default: begin
      end
    endcase
    if (cfg_wr_i) begin
      primed_d = 1'b0;
      smooth_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= '0;
      primed_q <= 1'b0;
    end else begin
      smooth_q <= smooth_d;
      primed_q <= primed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    neg_q   <= neg_d;
    mag_q   <= mag_d;
    sq_q    <= sq_d;
    cube_q  <= cube_d;
    res_q   <= res_d;
    passv_q <= passv_d;
    expo_mag_q <= expo_mag_d;
    expo_neg_q <= expo_neg_d;
  end

  assign sts_o.div_busy = div_busy;
  assign result_o = res_q;

  property p_cfg_clears;
    @(posedge clk_i) disable iff (!rst_ni) cfg_wr_i |=> (!primed_q && smooth_q == '0);
  endproperty
  a_cfg_clears: assert property (p_cfg_clears) else $error("config write left filter primed");

  property p_filter_primes;
    @(posedge clk_i) disable iff (!rst_ni) (cmd_i.op == OpFilter && !cfg_wr_i) |=> primed_q;
  endproperty
  a_filter_primes: assert property (p_filter_primes) else $error("filter not primed");

  property p_no_start_busy;
    @(posedge clk_i) disable iff (!rst_ni) cmd_i.div_start |-> !div_busy;
  endproperty
  a_no_start_busy: assert property (p_no_start_busy) else $error("divider restarted while busy");

endmodule

[rtl/core/sac_ctrl.sv]
// Controller sequencing the datapath steps for one word.
module sac_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  sac_pkg::cfg_t    cfg_i,
  input  sac_pkg::dp_sts_t sts_i,
  output sac_pkg::dp_cmd_t cmd_o,
  output logic             load_o,
  output logic             busy_o
);
  import sac_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StFilter, StMapGo, StMapWait, StDz, StDzWait, StCube1, StCube2,
    StExpoGo, StExpoWait, StFinish, StOut
  } state_e;

  state_e state_q;
  logic   accept;
  logic   dz_div;

  assign accept     = in_valid_i && (state_q == StIdle);
  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign load_o     = accept;
  assign busy_o     = (state_q != StIdle);
  assign dz_div     = !cfg_i.unipolar_mode && (cfg_i.center_deadzone != '0) &&
                      (cfg_i.center_deadzone < 16'd32767);

  always_comb begin
    cmd_o.op = OpNone;
    cmd_o.div_start = 1'b0;
    unique case (state_q)
      StFilter:  cmd_o.op = OpFilter;
      StMapGo: begin
        cmd_o.op = OpMap;
        cmd_o.div_start = 1'b1;
      end
      StDz: begin
        cmd_o.op = OpDzone;
        cmd_o.div_start = dz_div;
      end
      StCube1:   cmd_o.op = OpCube1;
      StCube2:   cmd_o.op = OpCube2;
      // The blend divide by one hundred is a reciprocal multiply in the datapath.
      StExpoGo:  cmd_o.op = OpExpo;
      StFinish:  cmd_o.op = OpFinish;
      default:   cmd_o.op = OpNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      unique case (state_q)
        StIdle:     if (accept) state_q <= StFilter;
        StFilter:   state_q <= StMapGo;
        StMapGo:    state_q <= StMapWait;
        StMapWait:  if (!sts_i.div_busy) state_q <= StDz;
        StDz:       state_q <= StDzWait;
        StDzWait:   if (!sts_i.div_busy) state_q <= StCube1;
        StCube1:    state_q <= StCube2;
        StCube2:    state_q <= StExpoGo;
        StExpoGo:   state_q <= StExpoWait;
        StExpoWait: if (!sts_i.div_busy) state_q <= StFinish;
        StFinish:   state_q <= StOut;
        StOut:      if (!out_stall_i) state_q <= StIdle;
        default:    state_q <= StIdle;
      endcase
    end
  end

  property p_out_holds;
    @(posedge clk_i) disable iff (!rst_ni) (out_valid_o && out_stall_i) |=> out_valid_o;
  endproperty
  a_out_holds: assert property (p_out_holds) else $error("result dropped");

  property p_accept_busy;
    @(posedge clk_i) disable iff (!rst_ni) accept |=> busy_o;
  endproperty
  a_accept_busy: assert property (p_accept_busy) else $error("accepted word not processed");

  property p_one_role;
    @(posedge clk_i) disable iff (!rst_ni) !(out_valid_o && !in_stall_o);
  endproperty
  a_one_role: assert property (p_one_role) else $error("input open while result pending");

endmodule

[rtl/core/stick_axis_conditioner.sv]
// Top level of the stick axis conditioner: registers, controller and datapath.
// Per word, the work is dominated by up to two passes of the shared 48-step divider
// (mapping and deadzone rescale); without the deadzone only the mapping pass runs.
// Throughput: one word at a time; a new word is taken only once the result has
// left, so a stalled result also holds off the next word.
// Reset: registers take their documented defaults and the filter is unprimed.
module stick_axis_conditioner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] axis_value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [sac_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sac_pkg::CfgDataW-1:0] cfg_data_i
);
  import sac_pkg::*;

  cfg_t     cfg_q;
  dp_cmd_t  cmd;
  dp_sts_t  sts;
  logic     load;
  logic     busy;
  logic     cfg_wr;

  // Configuration is always accepted; every index maps onto a register.
  assign cfg_ready_o = 1'b1;
  assign cfg_wr = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_low       <= 16'd0;
      cfg_q.range_center    <= 16'd32768;
      cfg_q.range_high      <= 16'hFFFF;
      cfg_q.unipolar_mode   <= 1'b0;
      cfg_q.invert_output   <= 1'b0;
      cfg_q.smoothing_shift <= 3'd0;
      cfg_q.expo_percent    <= 7'd0;
      cfg_q.center_deadzone <= 16'd0;
    end else if (cfg_wr) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegRangeLow:    cfg_q.range_low       <= cfg_data_i;
        RegRangeCenter: cfg_q.range_center    <= cfg_data_i;
        RegRangeHigh:   cfg_q.range_high      <= cfg_data_i;
        RegUnipolar:    cfg_q.unipolar_mode   <= cfg_data_i[0];
        RegInvert:      cfg_q.invert_output   <= cfg_data_i[0];
        RegShift:       cfg_q.smoothing_shift <= cfg_data_i[2:0];
        RegExpo:        cfg_q.expo_percent    <= cfg_data_i[6:0];
        RegDeadzone:    cfg_q.center_deadzone <= cfg_data_i;
        default:        cfg_q.range_low       <= cfg_q.range_low;
      endcase
    end
  end

  sac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_i       (cfg_q),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .load_o      (load),
    .busy_o      (busy)
  );

  sac_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .cfg_wr_i (cfg_wr),
    .load_i   (load),
    .sample_i (sample_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .result_o (axis_value_o)
  );

  property p_cfg_idle;
    @(posedge clk_i) disable iff (!rst_ni) cfg_wr |-> !busy;
  endproperty
  a_cfg_idle: assert property (p_cfg_idle) else $error("configuration written while busy");

  property p_result_stable;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_stall_i) |=> $stable(axis_value_o);
  endproperty
  a_result_stable: assert property (p_result_stable) else $error("result changed");

  property p_cfg_unprimes;
    @(posedge clk_i) disable iff (!rst_ni) (cfg_wr && !busy) |=> !busy;
  endproperty
  a_cfg_unprimes: assert property (p_cfg_unprimes) else $error("work started on config write");

endmodule

[tb/sv/stick_axis_conditioner_tb.sv]
// Self-checking testbench of the stick axis conditioner, with its own axis model.
`timescale 1ns / 1ps

module stick_axis_conditioner_tb;
  import sac_pkg::*;

  localparam int unsigned HalfPeriod = 10;
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned DrainCycles = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] sample_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] axis_value_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  stick_axis_conditioner u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .axis_value_o (axis_value_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Model copy of the registers and of the filter state.
  cfg_t        model_cfg;
  logic [15:0] model_smooth;
  bit          model_primed;

  logic [15:0] pending_samples[$];
  logic [15:0] expected_axis[$];

  bit          quiet_send;
  bit          quiet_recv;
  int unsigned hold_off;
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          timed_out;

  initial clk_i = 1'b0;
  always #(HalfPeriod) clk_i = ~clk_i;

  function automatic logic [15:0] sat_axis(longint v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  // Seeded low-pass filter; updates the model state.
  function automatic logic [15:0] filter_sample(logic [15:0] s);
    int delta, step, lim, sh;
    sh = model_cfg.smoothing_shift;
    if (!model_primed || sh == 0) begin
      model_smooth = s;
      model_primed = 1'b1;
      return s;
    end
    delta = int'(s) - int'(model_smooth);
    if (delta >= 0) begin
      step = delta >>> sh;
    end else begin
      lim = (1 << sh) - 1;
      step = -((-delta + lim) >>> sh);
    end
    if (step == 0 && delta != 0) step = (delta > 0) ? 1 : -1;
    model_smooth = 16'(int'(model_smooth) + step);
    return model_smooth;
  endfunction

  function automatic logic [15:0] condition_axis(logic [15:0] raw_in);
    longint lo, ce, hi, raw, outv, x, mag, dz, scaled, cubic, e;
    bit inverted;
    lo = model_cfg.range_low;
    ce = model_cfg.range_center;
    hi = model_cfg.range_high;
    raw = raw_in;
    inverted = lo > hi;
    if (raw < lo) raw = lo;
    if (raw > hi) raw = hi;
    if (model_cfg.unipolar_mode) begin
      outv = (inverted || hi == lo) ? 0 : ((raw - lo) * 65535) / (hi - lo);
    end else if (inverted) begin
      outv = 32768;
    end else if (raw <= ce) begin
      outv = (ce > lo) ? ((raw - lo) * 32768) / (ce - lo) : 32768;
    end else begin
      outv = (hi > ce) ? 32768 + ((raw - ce) * 32767) / (hi - ce) : 32768;
    end
    outv = outv & 16'hFFFF;
    if (!model_cfg.unipolar_mode) begin
      dz = model_cfg.center_deadzone;
      if (dz != 0 && dz < 32767) begin
        x = outv - 32768;
        mag = (x < 0) ? -x : x;
        if (mag <= dz) begin
          outv = 32768;
        end else begin
          scaled = ((mag - dz) * 32767) / (32767 - dz);
          if (scaled > 32767) scaled = 32767;
          outv = sat_axis(32768 + ((x < 0) ? -scaled : scaled));
        end
      end
      e = model_cfg.expo_percent;
      if (e != 0) begin
        x = outv - 32768;
        cubic = (x * x * x) / (64'sd32768 * 64'sd32768);
        outv = sat_axis(32768 + ((100 - e) * x + e * cubic) / 100);
      end
    end
    if (model_cfg.invert_output) outv = 65535 - outv;
    return outv[15:0];
  endfunction

  // Driver: offers queued samples, idling about 30 percent of the time unless quiet_send is set.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_i   <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pending_samples.size() > 0 && (quiet_send || $urandom_range(99) >= 30)) begin
        // Prediction happens on offer; the order of acceptance is the same.
        sample_i   <= pending_samples[0];
        expected_axis.push_back(condition_axis(filter_sample(pending_samples[0])));
        void'(pending_samples.pop_front());
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall, with an optional long hold-off counted here.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off    <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= quiet_recv ? 1'b0 : ($urandom_range(99) < 30);
    end
  end

  // Monitor: compares every accepted word with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_axis.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: axis_value %0d", axis_value_o);
      end else begin
        if (axis_value_o !== expected_axis[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("axis_value mismatch: expected %0d actual %0d",
                     expected_axis[0], axis_value_o);
        end
        void'(expected_axis.pop_front());
      end
    end
  end

  // Watchdog over cycles in which no word moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Write a register once everything is idle; the model copies it.
  task automatic write_reg(cfg_reg_e idx, logic [15:0] value);
    wait (pending_samples.size() == 0 && expected_axis.size() == 0 && !in_valid_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegRangeLow:    model_cfg.range_low = value;
      RegRangeCenter: model_cfg.range_center = value;
      RegRangeHigh:   model_cfg.range_high = value;
      RegUnipolar:    model_cfg.unipolar_mode = value[0];
      RegInvert:      model_cfg.invert_output = value[0];
      RegShift:       model_cfg.smoothing_shift = value[2:0];
      RegExpo:        model_cfg.expo_percent = value[6:0];
      default:        model_cfg.center_deadzone = value;
    endcase
    model_primed = 1'b0;
    model_smooth = '0;
  endtask

  task automatic push_sample(logic [15:0] s);
    pending_samples.push_back(s);
  endtask

  // Random calibration, extremes now and then.
  task automatic random_setting(int unsigned phase);
    logic [15:0] lo, hi, ce;
    lo = 16'($urandom_range(20000));
    hi = 16'hFFFF - 16'($urandom_range(20000));
    ce = 16'(($urandom_range(1) ? int'(lo) : int'(hi)) / 2 + 16384);
    if (phase % 5 == 0) begin
      lo = 16'h0000; hi = 16'hFFFF; ce = 16'h8000;
    end else if (phase % 7 == 0) begin
      lo = 16'($urandom); hi = 16'($urandom); ce = 16'($urandom);
    end
    write_reg(RegRangeLow, lo);
    write_reg(RegRangeHigh, hi);
    write_reg(RegRangeCenter, ce);
    write_reg(RegUnipolar, 16'($urandom_range(1)));
    write_reg(RegInvert, 16'($urandom_range(1)));
    write_reg(RegShift, 16'($urandom_range(phase % 4 == 0 ? 7 : 5)));
    write_reg(RegExpo, 16'(phase % 6 == 0 ? $urandom_range(127) : $urandom_range(100)));
    write_reg(RegDeadzone, 16'(phase % 8 == 0 ? $urandom : $urandom_range(8000)));
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    quiet_send  = 1'b0;
    quiet_recv  = 1'b0;
    hold_off    = 0;
    mismatches  = 0;
    model_cfg   = '{range_low: 16'd0, range_center: 16'd32768, range_high: 16'hFFFF,
                    unipolar_mode: 1'b0, invert_output: 1'b0, smoothing_shift: 3'd0,
                    expo_percent: 7'd0, center_deadzone: 16'd0};
    model_smooth = '0;
    model_primed = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: defaults, extremes of the sample and filter behaviour.
    push_sample(16'h0000); push_sample(16'hFFFF); push_sample(16'h8000);
    push_sample(16'h7FFF); push_sample(16'h5555); push_sample(16'hAAAA);
    write_reg(RegShift, 16'd3);
    // Small steps force the plus or minus one step of the filter.
    push_sample(16'h1000); push_sample(16'h1001); push_sample(16'h1000);
    push_sample(16'hFFFF); push_sample(16'h0000);
    write_reg(RegShift, 16'd7);
    push_sample(16'h4000); push_sample(16'hC000);
    write_reg(RegShift, 16'd0);
    write_reg(RegDeadzone, 16'd32767);
    write_reg(RegExpo, 16'd127);
    push_sample(16'hFFFF); push_sample(16'h0000); push_sample(16'h9000);
    write_reg(RegDeadzone, 16'd4000);
    write_reg(RegExpo, 16'd100);
    write_reg(RegInvert, 16'd1);
    push_sample(16'h8100); push_sample(16'h7000); push_sample(16'hFFFF);
    // Inverted range, then zero span in unipolar mode.
    write_reg(RegRangeLow, 16'hF000);
    write_reg(RegRangeHigh, 16'h1000);
    push_sample(16'h8000);
    write_reg(RegUnipolar, 16'd1);
    push_sample(16'h8000);
    write_reg(RegRangeLow, 16'h1000);
    push_sample(16'h0800); push_sample(16'h2000);

    // Random part: phases of fresh settings, one with a long receiver hold-off.
    for (int unsigned phase = 1; phase <= 16; phase++) begin
      random_setting(phase);
      quiet_send = (phase == 3);
      quiet_recv = (phase == 4);
      if (phase == 6) hold_off = 3000;
      for (int n = 0; n < 24; n++) begin
        case ($urandom_range(3))
          0:       push_sample(16'($urandom));
          1:       push_sample(16'($urandom_range(1) ? $urandom_range(255) :
                                   65535 - $urandom_range(255)));
          default: push_sample(16'(32768 + $signed($urandom_range(8000)) - 4000));
        endcase
      end
    end

    wait (pending_samples.size() == 0 && expected_axis.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/sac_pkg.sv
rtl/core/sac_divider.sv
rtl/core/sac_datapath.sv
rtl/core/sac_ctrl.sv
rtl/core/stick_axis_conditioner.sv
tb/sv/stick_axis_conditioner_tb.sv
